>>> sv/murmur2_hash32_stream_assert.svh
// Assertion macros for the streaming hash block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef MURMUR2_HASH32_STREAM_ASSERT_SVH
`define MURMUR2_HASH32_STREAM_ASSERT_SVH

// Checked on every rising clock edge, ignored while reset is high.
`define MM2_ASSERT_ACTIVE(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MM2_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mm2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_pkg
// Constants, operation codes and the control structs shared by the
// controller and the datapath of the streaming 32-bit hash block.
// ----------------------------------------------------------------------------
package mm2_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 3;

   localparam logic [WORD_W-1:0] MIX_MUL     = 32'h5bd1e995;
   localparam int                MIX_SHIFT   = 24;
   localparam int                FIN_SHIFT_A = 13;
   localparam int                FIN_SHIFT_B = 15;

   // Datapath operations, one per cycle.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_K_MIX,
      OP_K_MUL,
      OP_H_MIX,
      OP_TAIL,
      OP_FIN
   } op_type;

   typedef struct packed {
      logic   load;
      logic   use_seed;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full_word;
      logic partial_word;
      logic last_word;
   } status_type;

endpackage

>>> sv/mm2_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_req_if / mm2_rsp_if
// Valid/ready channels for message words in and finished hashes out.
// ----------------------------------------------------------------------------
interface mm2_req_if;
   logic                          valid;
   logic                          ready;
   logic [mm2_pkg::WORD_W-1:0]    data_word;
   logic [mm2_pkg::COUNT_W-1:0]   valid_bytes;
   logic                          last_word;
   logic [mm2_pkg::WORD_W-1:0]    seed_value;

   modport source (output valid, data_word, valid_bytes, last_word, seed_value,
                   input ready);
   modport sink (input valid, data_word, valid_bytes, last_word, seed_value,
                 output ready);
endinterface

interface mm2_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mm2_pkg::WORD_W-1:0]    hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

>>> sv/murmur2_hash32_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash32_stream
// Streaming 32-bit multiplicative hash over little-endian message words.
// ----------------------------------------------------------------------------
// Each beat on req_chan carries one message word, its count of valid bytes and
// a last flag; the seed is taken from the first beat of a message. A full word
// goes through the K_MIX, K_MUL and H_MIX steps, a partial word through the TAIL
// step and a beat with no bytes through none; a last beat adds a finalize step,
// which waits until the output register is free. Every step goes through the single multiply-by-constant unit. The
// finished hash waits in an output register on rsp_chan while the next
// message is already being accepted.
module murmur2_hash32_stream (
   input  logic       clock,
   input  logic       reset,
   mm2_req_if.sink    req_chan,
   mm2_rsp_if.source  rsp_chan
);

   mm2_pkg::cmd_type    cmd;
   mm2_pkg::status_type status;

   mm2_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mm2_datapath u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_data_word   (req_chan.data_word),
      .req_valid_bytes (req_chan.valid_bytes),
      .req_last_word   (req_chan.last_word),
      .req_seed_value  (req_chan.seed_value),
      .rsp_hash_value  (rsp_chan.hash_value)
   );

endmodule

>>> sv/mm2_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_datapath
// Running hash and key registers around one shared multiply-by-constant unit,
// plus the result register that holds a finished hash until it is taken.
// ----------------------------------------------------------------------------
module mm2_datapath (
   input  logic                          clock,
   input  mm2_pkg::cmd_type              cmd,
   output mm2_pkg::status_type           status,
   input  logic [mm2_pkg::WORD_W-1:0]    req_data_word,
   input  logic [mm2_pkg::COUNT_W-1:0]   req_valid_bytes,
   input  logic                          req_last_word,
   input  logic [mm2_pkg::WORD_W-1:0]    req_seed_value,
   output logic [mm2_pkg::WORD_W-1:0]    rsp_hash_value
);

   logic [mm2_pkg::WORD_W-1:0] h_ff, h_in;
   logic [mm2_pkg::WORD_W-1:0] k_ff, k_in;
   logic [mm2_pkg::WORD_W-1:0] hash_ff, hash_in;
   logic [mm2_pkg::WORD_W-1:0] byte_mask;
   logic [mm2_pkg::WORD_W-1:0] fin_pre;
   logic [mm2_pkg::WORD_W-1:0] mul_a;
   logic [mm2_pkg::WORD_W-1:0] product;

   // Counts of five and up saturate to a full word.
   assign status.full_word    = req_valid_bytes[2];
   assign status.partial_word = !req_valid_bytes[2] && (req_valid_bytes[1:0] != 2'd0);
   assign status.last_word    = req_last_word;

   always_comb begin
      case (req_valid_bytes[1:0])
         2'd1:    byte_mask = 32'h0000_00ff;
         2'd2:    byte_mask = 32'h0000_ffff;
         2'd3:    byte_mask = 32'h00ff_ffff;
         default: byte_mask = '1;
      endcase
   end

   assign fin_pre = h_ff ^ (h_ff >> mm2_pkg::FIN_SHIFT_A);

   always_comb begin
      case (cmd.op)
         mm2_pkg::OP_K_MIX: mul_a = k_ff;
         mm2_pkg::OP_K_MUL: mul_a = k_ff;
         mm2_pkg::OP_H_MIX: mul_a = h_ff;
         mm2_pkg::OP_TAIL:  mul_a = h_ff ^ k_ff;
         mm2_pkg::OP_FIN:   mul_a = fin_pre;
         default:           mul_a = h_ff;
      endcase
   end

   // Low 32 bits of the product only.
   assign product = mul_a * mm2_pkg::MIX_MUL;

   always_comb begin
      h_in    = h_ff;
      k_in    = k_ff;
      hash_in = hash_ff;
      if (cmd.load) begin
         if (cmd.use_seed) begin
            h_in = req_seed_value;
         end
         k_in = req_valid_bytes[2] ? req_data_word : (req_data_word & byte_mask);
      end
      case (cmd.op)
         mm2_pkg::OP_K_MIX: k_in = product ^ (product >> mm2_pkg::MIX_SHIFT);
         mm2_pkg::OP_K_MUL: k_in = product;
         mm2_pkg::OP_H_MIX: h_in = product ^ k_ff;
         mm2_pkg::OP_TAIL:  h_in = product;
         mm2_pkg::OP_FIN: begin
            hash_in = product ^ (product >> mm2_pkg::FIN_SHIFT_B);
            h_in    = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      k_ff    <= k_in;
      hash_ff <= hash_in;
   end

   assign rsp_hash_value = hash_ff;

endmodule

>>> sv/mm2_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_controller
// Sequences the datapath through the mixing steps of each beat, tracks
// message boundaries and owns the result valid flag.
// ----------------------------------------------------------------------------
module mm2_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mm2_pkg::status_type  status,
   output mm2_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_K_MIX,
      ST_K_MUL,
      ST_H_MIX,
      ST_TAIL,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      inside_ff, inside_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;
   logic      fin_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign fin_fire  = (state_ff == ST_FIN) && slot_free;

   always_comb begin
      cmd.load     = accept;
      cmd.use_seed = !inside_ff;
      case (state_ff)
         ST_K_MIX: cmd.op = mm2_pkg::OP_K_MIX;
         ST_K_MUL: cmd.op = mm2_pkg::OP_K_MUL;
         ST_H_MIX: cmd.op = mm2_pkg::OP_H_MIX;
         ST_TAIL:  cmd.op = mm2_pkg::OP_TAIL;
         ST_FIN:   cmd.op = fin_fire ? mm2_pkg::OP_FIN : mm2_pkg::OP_NONE;
         default:  cmd.op = mm2_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      inside_in    = inside_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in   = status.last_word;
               inside_in = 1'b1;
               if (status.full_word) begin
                  state_in = ST_K_MIX;
               end else if (status.partial_word) begin
                  state_in = ST_TAIL;
               end else if (status.last_word) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_K_MIX: state_in = ST_K_MUL;
         ST_K_MUL: state_in = ST_H_MIX;
         ST_H_MIX: state_in = last_ff ? ST_FIN : ST_IDLE;
         ST_TAIL:  state_in = last_ff ? ST_FIN : ST_IDLE;
         ST_FIN: begin
            // The finalizer waits until the result register can take the hash.
            if (fin_fire) begin
               rsp_valid_in = 1'b1;
               inside_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inside_ff    <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inside_ff    <= inside_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/mm2_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_checker
// Port-level checks on the streaming hash block, bound to the top level.
// ----------------------------------------------------------------------------
`include "murmur2_hash32_stream_assert.svh"

module mm2_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [mm2_pkg::COUNT_W-1:0]   req_valid_bytes,
   input logic                          req_last_word,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mm2_pkg::WORD_W-1:0]    rsp_hash_value
);

   logic req_beat;
   logic empty_last;

   assign req_beat   = req_valid && req_ready;
   assign empty_last = req_last_word && (req_valid_bytes == '0);

   // A stalled result keeps its valid and its hash.
   `MM2_ASSERT_ACTIVE(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hash_value)), "result changed while stalled")

   `MM2_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   // No new beat is taken while a full word goes through its K_MIX, K_MUL and H_MIX steps.
   `MM2_ASSERT_ACTIVE(a_full_busy, clock, reset, (req_beat && req_valid_bytes[2]) |=> !req_ready ##1 !req_ready ##1 !req_ready, "new beat taken during full-word mixing")

   // A last beat with no bytes and a free output slot goes straight to FIN and is answered without a stall.
   `MM2_ASSERT_ACTIVE(a_empty_result, clock, reset, (req_beat && empty_last && !rsp_valid) |=> ##1 rsp_valid, "empty message not answered in time")

endmodule

bind murmur2_hash32_stream mm2_checker u_mm2_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_valid_bytes (req_chan.valid_bytes),
   .req_last_word   (req_chan.last_word),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hash_value  (rsp_chan.hash_value)
);
